### design/acs_pkg.sv
// acs_pkg: shared types and constants for the affine cipher stream block.
// No dependencies; imported by the controller, the datapath and the top level.
package acs_pkg;

  localparam int unsigned MOD_W     = 5;   // residue / alphabet width
  localparam int unsigned IDX_W     = 2;   // config register index width
  localparam int unsigned CFG_W     = 8;   // widest config register
  localparam int unsigned ALPHA_LEN = 26;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_MULTKEY = 2'd1;
  localparam logic [IDX_W-1:0] REG_ADDKEY  = 2'd2;
  localparam logic [IDX_W-1:0] REG_MODULUS = 2'd3;

  localparam logic       MODE_ENC = 1'b0;
  localparam logic       MODE_DEC = 1'b1;

  localparam logic [MOD_W-1:0] MOD_MAX = 5'd26;
  localparam logic [MOD_W-1:0] MOD_MIN = 5'd2;

  // byte codes
  localparam logic [7:0] PREFIX_BYTE = 8'hC3;
  localparam logic [7:0] ASCII_UA    = 8'h41;  // 'A'
  localparam logic [7:0] ASCII_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] ASCII_LA    = 8'h61;  // 'a'
  localparam logic [7:0] ASCII_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] FOLD_MASK   = 8'hDF;
  localparam logic [7:0] ACCENT_N    = 8'h91;  // n-tilde after folding (0xB1 before)

  // sequencer step limits
  localparam logic [MOD_W-1:0] REDUCE_LAST = 5'd7;
  localparam logic [MOD_W-1:0] DMUL_LAST   = 5'd5;
  localparam logic [MOD_W-1:0] FILL_LAST   = 5'd25;

  typedef enum logic [2:0] {
    ST_KEY_INIT,
    ST_REDUCE,
    ST_SEARCH,
    ST_DMUL,
    ST_FILL,
    ST_IDLE,
    ST_EXEC
  } acs_state_t;

  typedef struct packed {
    logic             key_init;
    logic             reduce_step;
    logic             search_init;
    logic             search_step;
    logic             dmul_init;
    logic             dmul_step;
    logic             fill_step;
    logic             accept;
    logic             commit;
    logic             load_out;
    logic [MOD_W-1:0] step;
  } acs_cmd_t;

  typedef struct packed {
    logic search_done;
    logic res_valid;
    logic out_busy;
  } acs_status_t;

endpackage

### design/acs_stream_if.sv
// acs_stream_if: valid/ready channel interfaces for the byte input and
// the cipher result output. Depends on nothing.
interface acs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface acs_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       key_error;
  modport source (output valid, output out_char, output key_error, input ready);
  modport sink   (input valid, input out_char, input key_error, output ready);
endinterface

### design/acs_datapath.sv
// acs_datapath: config registers, key derivation arithmetic, lookup tables,
// byte decode and output register. Depends on acs_pkg.
module acs_datapath import acs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  reg_index,
  input  logic [CFG_W-1:0]  wr_data,
  input  logic [7:0]        byte_in,
  input  logic              out_ready,
  input  acs_cmd_t          cmd,
  output acs_status_t       status,
  output logic              out_valid,
  output logic [6:0]        out_char,
  output logic              key_error
);

  logic             mode;
  logic [7:0]       mult_key;
  logic [7:0]       add_key;
  logic [MOD_W-1:0] modulus;
  logic             key_valid;
  logic [MOD_W-1:0] key_inverse;
  logic [MOD_W-1:0] rem_a, rem_b;       // a mod m, b mod m
  logic [MOD_W-1:0] search_i, search_p; // candidate and a*i mod m
  logic [MOD_W-1:0] acc;                // ainv*t mod m, doubles as decrypt entry
  logic [MOD_W-1:0] fill_e, fill_t;
  logic [MOD_W-1:0] enc_tab [ALPHA_LEN];
  logic [MOD_W-1:0] dec_tab [ALPHA_LEN];
  logic [7:0]       byte_reg;
  logic             prefix_pending;

  function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] x,
                                               input logic [MOD_W-1:0] y,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  // shift in one bit of the dividend, one restoring step
  function automatic logic [MOD_W-1:0] mod_shift(input logic [MOD_W-1:0] r,
                                                 input logic bit_in,
                                                 input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {r, bit_in};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  // second byte of a 0xC3 sequence: {hit, letter index}
  function automatic logic [MOD_W:0] accent_letter(input logic [7:0] c);
    logic [7:0] u;
    u = c & FOLD_MASK;
    if (u >= 8'h80 && u <= 8'h84)      return {1'b1, 5'd0};   // A
    else if (u >= 8'h88 && u <= 8'h8B) return {1'b1, 5'd4};   // E
    else if (u >= 8'h8C && u <= 8'h8F) return {1'b1, 5'd8};   // I
    else if (u >= 8'h92 && u <= 8'h96) return {1'b1, 5'd14};  // O
    else if (u >= 8'h99 && u <= 8'h9C) return {1'b1, 5'd20};  // U
    else if (u == ACCENT_N)            return {1'b1, 5'd13};  // N
    else                               return {1'b0, 5'd0};
  endfunction

  logic [MOD_W-1:0] rbit_pos, dbit_pos, t0, dbl;
  logic [4:0]       mod_wr;

  assign rbit_pos = REDUCE_LAST - cmd.step;
  assign dbit_pos = DMUL_LAST - cmd.step;
  assign t0       = (rem_b == '0) ? '0 : modulus - rem_b;   // (0 - b) mod m
  assign dbl      = mod_add(acc, acc, modulus);
  assign mod_wr   = wr_data[4:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_ENC;
      mult_key <= 8'd1;
      add_key  <= 8'd0;
      modulus  <= MOD_MAX;
    end else if (wr_en) begin
      case (reg_index)
        REG_MODE:    mode     <= wr_data[0];
        REG_MULTKEY: mult_key <= wr_data;
        REG_ADDKEY:  add_key  <= wr_data;
        REG_MODULUS: begin
          if (mod_wr > MOD_MAX)      modulus <= MOD_MAX;
          else if (mod_wr < MOD_MIN) modulus <= MOD_MIN;
          else                       modulus <= mod_wr;
        end
        default: ;
      endcase
    end
  end

  // key derivation: reduce, inverse search, decrypt start value, then table fill
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid   <= 1'b1;
      key_inverse <= 5'd1;
    end else if (cmd.search_step && search_p != 5'd1 && search_i == modulus - 5'd1) begin
      key_valid   <= 1'b0;
      key_inverse <= '0;
    end else if (cmd.search_step && search_p == 5'd1) begin
      key_valid   <= 1'b1;
      key_inverse <= search_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      rem_a <= '0;
      rem_b <= '0;
    end else if (cmd.reduce_step) begin
      rem_a <= mod_shift(rem_a, mult_key[rbit_pos[2:0]], modulus);
      rem_b <= mod_shift(rem_b, add_key[rbit_pos[2:0]], modulus);
    end

    if (cmd.search_init) begin
      search_i <= 5'd1;
      search_p <= rem_a;
    end else if (cmd.search_step) begin
      search_i <= search_i + 5'd1;
      search_p <= mod_add(search_p, rem_a, modulus);
    end

    if (cmd.dmul_init) begin
      acc    <= '0;
      fill_e <= rem_b;
      fill_t <= t0;
    end else if (cmd.dmul_step) begin
      acc <= t0[dbit_pos[2:0]] ? mod_add(dbl, key_inverse, modulus) : dbl;
    end else if (cmd.fill_step) begin
      enc_tab[cmd.step] <= fill_e;
      dec_tab[cmd.step] <= acc;
      fill_e <= mod_add(fill_e, rem_a, modulus);
      if (fill_t + 5'd1 == modulus) begin
        fill_t <= '0;
        acc    <= '0;
      end else begin
        fill_t <= fill_t + 5'd1;
        acc    <= mod_add(acc, key_inverse, modulus);
      end
    end

    if (cmd.accept) byte_reg <= byte_in;
  end

  // byte decode and lookup
  logic             res_valid, res_err, prefix_next;
  logic [MOD_W-1:0] res_idx;
  logic [MOD_W:0]   acc_hit;
  logic [7:0]       c_low, c_up;

  assign acc_hit = accent_letter(byte_reg);
  assign c_low   = byte_reg - ASCII_LA;
  assign c_up    = byte_reg - ASCII_UA;

  always_comb begin
    res_valid   = 1'b0;
    res_err     = 1'b0;
    res_idx     = '0;
    prefix_next = 1'b0;
    if (!key_valid) begin
      res_valid = 1'b1;
      res_err   = 1'b1;
    end else if (mode == MODE_ENC) begin
      if (prefix_pending) begin
        res_valid = acc_hit[MOD_W];
        res_idx   = enc_tab[acc_hit[MOD_W-1:0]];
      end else if (byte_reg == PREFIX_BYTE) begin
        prefix_next = 1'b1;
      end else if (byte_reg >= ASCII_LA && byte_reg <= ASCII_LZ) begin
        res_valid = 1'b1;
        res_idx   = enc_tab[c_low[MOD_W-1:0]];
      end else if (byte_reg >= ASCII_UA && byte_reg <= ASCII_UZ) begin
        res_valid = 1'b1;
        res_idx   = enc_tab[c_up[MOD_W-1:0]];
      end
    end else begin
      if (byte_reg >= ASCII_UA && byte_reg <= ASCII_UZ) begin
        res_valid = 1'b1;
        res_idx   = dec_tab[c_up[MOD_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pending <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.commit) prefix_pending <= prefix_next;
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      key_error <= res_err;
      out_char  <= res_err ? 7'd0 : ASCII_UA[6:0] + {2'b00, res_idx};
    end
  end

  assign status.search_done = (search_p == 5'd1) || (search_i == modulus - 5'd1);
  assign status.res_valid   = res_valid;
  assign status.out_busy    = out_valid && !out_ready;

endmodule

### design/acs_ctrl.sv
// acs_ctrl: sequencer for key derivation and per-byte handling.
// Depends on acs_pkg; drives acs_datapath through acs_cmd_t.
module acs_ctrl import acs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        in_valid,
  output logic        in_ready,
  input  acs_status_t status,
  output acs_cmd_t    cmd
);

  acs_state_t       state, state_next;
  logic [MOD_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KEY_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_KEY_INIT: begin
        state_next = ST_REDUCE;
        cnt_next   = '0;
      end
      ST_REDUCE: begin
        if (cnt == REDUCE_LAST) begin
          state_next = ST_SEARCH;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ST_SEARCH: begin
        if (cnt == '0) begin
          cnt_next = 5'd1;
        end else if (status.search_done) begin
          state_next = ST_DMUL;
          cnt_next   = '0;
        end
      end
      ST_DMUL: begin
        if (cnt == DMUL_LAST) begin
          state_next = ST_FILL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ST_FILL: begin
        if (cnt == FILL_LAST) state_next = ST_IDLE;
        else                  cnt_next   = cnt + 5'd1;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.res_valid || !status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_KEY_INIT;
    endcase
    // any config write restarts key setup
    if (cfg_write) begin
      state_next = ST_KEY_INIT;
      cnt_next   = '0;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.step = cnt;
    in_ready = 1'b0;
    case (state)
      ST_KEY_INIT: cmd.key_init    = 1'b1;
      ST_REDUCE:   cmd.reduce_step = 1'b1;
      ST_SEARCH: begin
        if (cnt == '0) cmd.search_init = 1'b1;
        else           cmd.search_step = 1'b1;
      end
      ST_DMUL: begin
        if (cnt == '0) cmd.dmul_init = 1'b1;
        else           cmd.dmul_step = 1'b1;
      end
      ST_FILL: cmd.fill_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        if (!status.res_valid) begin
          cmd.commit = 1'b1;
        end else if (!status.out_busy) begin
          cmd.commit   = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/affine_cipher_stream_top.sv
// affine_cipher_stream_top: top level of the affine cipher byte stream block.
// Depends on acs_pkg, acs_stream_if, acs_ctrl and acs_datapath.
//
// Usage:
//   byte_ch   (sink)   one raw text byte per transaction.
//   result_ch (source) zero or one cipher letter per byte: out_char is the
//                      ASCII letter, key_error flags a key not coprime with m.
//   wr_en/reg_index/wr_data write mode, mult_key, add_key, modulus; write
//   only while no byte is in flight.
// Timing:
//   A byte is accepted in the idle state and decoded the next cycle; its
//   result goes into the output register from the execute state once that
//   register is free. No new byte is taken before the last one has left
//   the execute state with its single table lookup.
// Key setup:
//   After reset and after every config write, ready stays low while the
//   sequencer derives the key: an init step, a mod m and b mod m one bit
//   at a time, the inverse search, the decrypt start value and the fill
//   of the encrypt and decrypt tables.
// Stall:
//   While a result waits in the output register the next byte is still
//   accepted; it then holds in the execute state until the register frees.
//   Bytes that give no result never wait.
module affine_cipher_stream_top import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  acs_byte_if.sink         byte_ch,
  acs_result_if.source     result_ch,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0] wr_data
);

  acs_cmd_t    cmd;
  acs_status_t status;

  // sequencer: owns ready and all step timing
  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (wr_en),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // config, key arithmetic, tables and the output register
  acs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .reg_index (reg_index),
    .wr_data   (wr_data),
    .byte_in   (byte_ch.byte_in),
    .out_ready (result_ch.ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result_ch.valid),
    .out_char  (result_ch.out_char),
    .key_error (result_ch.key_error)
  );

endmodule

### design/acs_checker.sv
// acs_checker: port-level assertions for affine_cipher_stream_top,
// attached by the bind below. Depends on nothing else.
module acs_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       key_error,
  input logic       wr_en
);

  // key error results carry no letter
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_error |-> out_char == 7'd0)
    else $error("key error result with nonzero out_char");

  // good results are upper-case letters
  a_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_error |-> out_char >= 7'h41 && out_char <= 7'h5A)
    else $error("result outside A..Z");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(key_error))
    else $error("stalled result changed");

  // one byte at a time: execute cycle follows every accepted transaction
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready |=> !byte_ready)
    else $error("ready high right after a transaction");

  // a config write starts key setup
  a_cfg_setup: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !byte_ready)
    else $error("ready high right after config write");

endmodule

bind affine_cipher_stream_top acs_checker u_acs_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_ch.valid),
  .byte_ready (byte_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .out_char   (result_ch.out_char),
  .key_error  (result_ch.key_error),
  .wr_en      (wr_en)
);

### bench/acs_cipher_checker.sv
// acs_cipher_checker: passive checker for the affine cipher stream block.
// Tracks the config writes, predicts each cipher letter and compares results.
// Depends on acs_pkg and the channel interfaces in acs_stream_if.
`timescale 1ns / 100ps

module acs_cipher_checker import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  acs_byte_if              byte_ch,
  acs_result_if            result_ch,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0] wr_data,
  output int               fail_count,
  output int               outstanding,
  output int               letter_count,
  output int               key_error_count
);

  typedef struct packed {
    logic [6:0] letter;
    logic       key_err;
  } cipher_out_t;

  // shadow of the block's registers and derived key state
  logic             mode_q;
  logic [7:0]       mult_q;
  logic [7:0]       add_q;
  logic [MOD_W-1:0] mod_q;
  logic             prefix_q;
  logic [MOD_W-1:0] inv_q;
  logic             valid_q;

  cipher_out_t letters_due[$];

  // inverse of a mod m by search; no inverse means a bad key
  function automatic void rederive_key();
    int m;
    int am;
    m = int'(mod_q);
    am = int'(mult_q) % m;
    valid_q = 1'b0;
    inv_q = '0;
    for (int i = 1; i < m; i++) begin
      if (!valid_q && (am * i) % m == 1) begin
        valid_q = 1'b1;
        inv_q = i[MOD_W-1:0];
      end
    end
  endfunction

  function automatic void take_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    logic [MOD_W-1:0] v;
    v = d[MOD_W-1:0];
    case (idx)
      REG_MODE:    mode_q = d[0];
      REG_MULTKEY: mult_q = d;
      REG_ADDKEY:  add_q = d;
      REG_MODULUS: begin
        if (v > MOD_MAX) v = MOD_MAX;
        else if (v < MOD_MIN) v = MOD_MIN;
        mod_q = v;
      end
    endcase
    rederive_key();
  endfunction

  // base letter index of the byte after the 0xC3 prefix, -1 if none
  function automatic int accent_base(input logic [7:0] c);
    logic [7:0] u;
    u = c & FOLD_MASK;
    if (u >= 8'h80 && u <= 8'h84) return 0;   // A
    if (u >= 8'h88 && u <= 8'h8B) return 4;   // E
    if (u >= 8'h8C && u <= 8'h8F) return 8;   // I
    if (u >= 8'h92 && u <= 8'h96) return 14;  // O
    if (u >= 8'h99 && u <= 8'h9C) return 20;  // U
    if (u == ACCENT_N) return 13;             // N
    return -1;
  endfunction

  function automatic void cipher_byte(input logic [7:0] c);
    int          m;
    int          x;
    int          r;
    cipher_out_t e;
    m = int'(mod_q);
    x = -1;
    r = -1;
    if (!valid_q) begin
      prefix_q = 1'b0;
      e.letter = '0;
      e.key_err = 1'b1;
      letters_due.push_back(e);
    end else begin
      if (mode_q == MODE_ENC) begin
        if (prefix_q) begin
          prefix_q = 1'b0;
          x = accent_base(c);
        end else if (c == PREFIX_BYTE) begin
          prefix_q = 1'b1;
        end else if (c >= ASCII_LA && c <= ASCII_LZ) begin
          x = int'(c) - int'(ASCII_LA);
        end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
          x = int'(c) - int'(ASCII_UA);
        end
        if (x >= 0) r = (int'(mult_q) * x + int'(add_q)) % m;
      end else begin
        prefix_q = 1'b0;
        if (c >= ASCII_UA && c <= ASCII_UZ) begin
          r = (int'(c) - int'(ASCII_UA) + m * 256 - int'(add_q)) % m;
          r = (int'(inv_q) * r) % m;
        end
      end
      if (r >= 0) begin
        e.letter = ASCII_UA[6:0] + r[6:0];
        e.key_err = 1'b0;
        letters_due.push_back(e);
      end
    end
  endfunction

  always @(posedge clk) begin
    cipher_out_t e;
    if (rst) begin
      mode_q   = MODE_ENC;
      mult_q   = 8'd1;
      add_q    = 8'd0;
      mod_q    = MOD_MAX;
      prefix_q = 1'b0;
      inv_q    = 5'd1;
      valid_q  = 1'b1;
      letters_due.delete();
      fail_count      <= 0;
      outstanding     <= 0;
      letter_count    <= 0;
      key_error_count <= 0;
    end else begin
      // results first: nothing accepted on this edge can already be out
      if (result_ch.valid && result_ch.ready) begin
        if (letters_due.size() == 0) begin
          if (fail_count < 10)
            $display("%t: unexpected result out_char=%0d key_error=%0b", $realtime,
                     result_ch.out_char, result_ch.key_error);
          fail_count <= fail_count + 1;
        end else begin
          e = letters_due.pop_front();
          if (result_ch.out_char !== e.letter || result_ch.key_error !== e.key_err) begin
            if (fail_count < 10)
              $display("%t: mismatch out_char exp %0d got %0d, key_error exp %0b got %0b",
                       $realtime, e.letter, result_ch.out_char, e.key_err,
                       result_ch.key_error);
            fail_count <= fail_count + 1;
          end
          if (e.key_err) key_error_count <= key_error_count + 1;
          else letter_count <= letter_count + 1;
        end
      end
      if (wr_en) take_write(reg_index, wr_data);
      if (byte_ch.valid && byte_ch.ready) cipher_byte(byte_ch.byte_in);
      outstanding <= letters_due.size();
    end
  end

endmodule

### bench/tb_affine_cipher_stream_top.sv
// tb_affine_cipher_stream_top: stimulus and verdict for the affine cipher stream block.
// Depends on acs_pkg, acs_stream_if, affine_cipher_stream_top and acs_cipher_checker.
`timescale 1ns / 100ps

module tb_affine_cipher_stream_top;
  import acs_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int HOLD_CYCLES  = 300;         // long output stall for the pressure phase
  localparam int DRAIN_CYCLES = 12;          // covers a byte still in flight with no result
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 64;
  localparam int TIMEOUT_NS   = 10_000_000;  // far above the slowest clean run

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic [IDX_W-1:0] reg_index = '0;
  logic [CFG_W-1:0] wr_data = '0;

  acs_byte_if   byte_ch();
  acs_result_if result_ch();

  int fail_count;
  int outstanding;
  int letter_count;
  int key_error_count;

  // knobs and counters shared by the stimulus, the sender and the result drain
  bit   src_idle_en = 1'b0;
  bit   sink_idle_en = 1'b0;
  bit   long_hold = 1'b0;
  int   hold_count = 0;
  int   bytes_sent = 0;
  int   settings_run = 0;
  logic cur_mode = MODE_ENC;

  affine_cipher_stream_top DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .wr_en     (wr_en),
    .reg_index (reg_index),
    .wr_data   (wr_data)
  );

  acs_cipher_checker cipher_chk (
    .clk             (clk),
    .rst             (rst),
    .byte_ch         (byte_ch),
    .result_ch       (result_ch),
    .wr_en           (wr_en),
    .reg_index       (reg_index),
    .wr_data         (wr_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .letter_count    (letter_count),
    .key_error_count (key_error_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // hard stop in case a transaction never completes
  initial begin
    #(TIMEOUT_NS);
    $display("tb_affine_cipher_stream_top NOT OK");
    $finish;
  end

  // Result drain: mostly ready, random stall bursts while enabled, and one
  // long hold-off on request so the output register and execute stage both
  // fill and the input side backs up.
  initial begin : result_drain
    int burst;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_count++;
        long_hold = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 16);
        result_ch.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // One byte transaction. valid stays high from one byte to the next unless an
  // idle burst is inserted, so it is never dropped and raised in the same step.
  task automatic send(input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // Ready held high on back-to-back edges: the key derivation has finished.
  task automatic await_idle();
    int run;
    run = 0;
    while (run < 2) begin
      @(posedge clk);
      run = byte_ch.ready ? run + 1 : 0;
    end
  endtask

  // Stop offering bytes, collect every pending letter, then give a trailing
  // byte with no result time to leave the execute stage.
  task automatic quiesce();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    wr_en     <= 1'b1;
    reg_index <= idx;
    wr_data   <= d;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_MODE) cur_mode = d[0];
    await_idle();
  endtask

  task automatic configure(input logic [7:0] mode_raw, input logic [7:0] a_raw,
                           input logic [7:0] b_raw, input logic [7:0] m_raw);
    quiesce();
    write_reg(REG_MODE, mode_raw);
    write_reg(REG_MULTKEY, a_raw);
    write_reg(REG_ADDKEY, b_raw);
    write_reg(REG_MODULUS, m_raw);
    settings_run++;
  endtask

  // Mostly well-formed text: letters and accent pairs, with raw bytes as noise.
  task automatic random_text(input int n, input bit letters_only);
    int         k;
    int         pick;
    logic [7:0] b;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 9);
      if (!letters_only && cur_mode == MODE_ENC && pick < 2) begin
        // accent pair; the second byte is mostly from the accented block
        b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : (8'h80 | 8'($urandom_range(0, 63)));
        send(PREFIX_BYTE);
        send(b);
        k += 2;
      end else if (letters_only || pick < 7) begin
        b = ASCII_UA + 8'($urandom_range(0, 25));
        if (cur_mode == MODE_ENC && $urandom_range(0, 1) == 1) b = b | 8'h20;
        send(b);
        k++;
      end else begin
        send(8'($urandom));
        k++;
      end
    end
  endtask

  initial begin : stimulus
    // encrypt boundaries, non-letters and prefix handling; ends with a prefix pending
    logic [7:0] enc_seq [21] = '{
      ASCII_UA, ASCII_UZ, ASCII_LA, ASCII_LZ, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B,
      PREFIX_BYTE, 8'h80, PREFIX_BYTE, 8'hB1, PREFIX_BYTE, 8'h91,
      PREFIX_BYTE, PREFIX_BYTE, PREFIX_BYTE, ASCII_UA, PREFIX_BYTE
    };
    logic [7:0] mode_raw, a_raw, b_raw, m_raw;
    int         m_eff, g1, g2, gt;
    bit         want_valid;
    bit         letters_only;

    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;

    // reset once, then wait out the key setup of the default key
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    await_idle();

    // ---- directed part ----
    // Reset settings: encrypt, a=1, b=0, m=26. Covers case folding, the
    // non-letters around both letter ranges, accent pairs including n-tilde,
    // a prefix eating another prefix and a plain letter as a bad second byte.
    foreach (enc_seq[i]) send(enc_seq[i]);

    // Switch to decrypt with the prefix still pending: the decrypt step drops it.
    // Wide data: only bit 0 of the mode register counts.
    quiesce();
    write_reg(REG_MODE, 8'hFF);
    send(ASCII_UA + 8'd1);
    send(ASCII_UZ);
    send(8'h5B);
    send(ASCII_LA);

    // Back to encrypt: 0x80 alone is no letter, proving the prefix was dropped.
    quiesce();
    write_reg(REG_MODE, 8'hFE);
    send(8'h80);
    send(PREFIX_BYTE);

    // Bad key (13 shares a factor with 26): every byte is a key error and the
    // pending prefix is dropped.
    quiesce();
    write_reg(REG_MULTKEY, 8'd13);
    send(ASCII_LA);
    send(PREFIX_BYTE);
    quiesce();
    write_reg(REG_MULTKEY, 8'd1);
    send(8'h80);
    send(ASCII_LZ);

    // Modulus clamping from below and above, plus the top additive key.
    quiesce();
    write_reg(REG_MODULUS, 8'd1);
    send(ASCII_UZ);
    quiesce();
    write_reg(REG_MODULUS, 8'h1F);
    write_reg(REG_ADDKEY, 8'hFF);
    send(ASCII_UA + 8'd16);

    // ---- random part ----
    for (int p = 0; p < RAND_PHASES; p++) begin
      letters_only = 1'b0;
      case (p)
        0: begin mode_raw = 8'h00; a_raw = 8'hFF; b_raw = 8'hFF; m_raw = 8'd26; end
        1: begin mode_raw = 8'h01; a_raw = 8'hFF; b_raw = 8'hFF; m_raw = 8'd26; end
        // a=0 never has an inverse; raw modulus 0 clamps to 2
        2: begin mode_raw = 8'h00; a_raw = 8'h00; b_raw = 8'h00; m_raw = 8'h00; end
        3: begin mode_raw = 8'h01; a_raw = 8'h03; b_raw = 8'h00; m_raw = 8'd2;  end
        // pressure phase: steady letters against a long output stall
        4: begin
          mode_raw = 8'h00; a_raw = 8'd5; b_raw = 8'd8; m_raw = 8'd26;
          letters_only = 1'b1;
        end
        default: begin
          mode_raw = {7'($urandom), 1'($urandom_range(0, 1))};
          b_raw = 8'($urandom);
          if ($urandom_range(0, 3) == 0) m_raw = 8'($urandom);
          else m_raw = {3'($urandom), 5'($urandom_range(2, 26))};
          m_eff = int'(m_raw[4:0]);
          if (m_eff > 26) m_eff = 26;
          if (m_eff < 2) m_eff = 2;
          // most settings use a valid key so the cipher path gets the traffic
          want_valid = ($urandom_range(0, 4) != 0);
          do begin
            a_raw = 8'($urandom);
            g1 = int'(a_raw);
            g2 = m_eff;
            while (g2 != 0) begin
              gt = g1 % g2;
              g1 = g2;
              g2 = gt;
            end
          end while (want_valid && g1 != 1);
        end
      endcase

      configure(mode_raw, a_raw, b_raw, m_raw);

      // idling on both sides for most phases; phase 6 runs at full rate and
      // the closing phases have no idling at all
      src_idle_en  = (p < RAND_PHASES - 3) && (p != 6);
      sink_idle_en = (p < RAND_PHASES - 3) && (p != 6);
      if (p == 4) long_hold = 1'b1;

      random_text(PHASE_ITEMS, letters_only);
    end

    // wait out every pending letter and the last byte still in flight
    quiesce();

    $display("%0d bytes over %0d key settings: %0d letters and %0d key errors checked",
             bytes_sent, settings_run, letter_count, key_error_count);
    $display("long output stalls: %0d, mismatches: %0d", hold_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_affine_cipher_stream_top OK");
    end else begin
      $display("tb_affine_cipher_stream_top NOT OK");
    end
    $finish;
  end

endmodule
